// ===== sv/gra_pkg.sv =====
package gra_pkg;

	// angle accumulator width and derived widths
	localparam int ANGLE_W = 48;
	localparam int RATE_W  = 16;
	localparam int TIME_W  = 32;
	localparam int RSUM_W  = RATE_W + 1;
	localparam int INC_W   = TIME_W + RSUM_W;
	localparam int SUM_W   = ((ANGLE_W > INC_W) ? ANGLE_W : INC_W) + 1;

	// divider lane sizing: |(raw - offset) * 10| needs 20 bits
	localparam int DIFF_W  = RATE_W + 1;
	localparam int TIMES_W = DIFF_W + 4;
	localparam int MAG_W   = TIMES_W - 1;
	localparam int DIVR_W  = 16;
	localparam int REM_W   = DIVR_W + 1;
	localparam int DIV_ITER = MAG_W;
	localparam int CNT_W   = $clog2(DIV_ITER);

	// configuration register indexes
	localparam int REG_IDX_W = 2;
	localparam int CFG_W     = 16;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET_X   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET_Z   = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_RATE_SCALE = 2'd3;
	localparam logic [DIVR_W-1:0] RATE_SCALE_RESET = 16'd1310;

	// item payloads
	typedef struct packed {
		logic signed [RATE_W-1:0] raw_rate_x;
		logic signed [RATE_W-1:0] raw_rate_y;
		logic signed [RATE_W-1:0] raw_rate_z;
		logic signed [TIME_W-1:0] time_start_ms;
		logic signed [TIME_W-1:0] time_stop_ms;
	} sample_t;

	typedef struct packed {
		logic signed [RATE_W-1:0]  rate_x_dps;
		logic signed [RATE_W-1:0]  rate_y_dps;
		logic signed [RATE_W-1:0]  rate_z_dps;
		logic signed [ANGLE_W-1:0] roll_angle;
		logic signed [ANGLE_W-1:0] pitch_angle;
	} result_t;

	// controls from the sequencer to each divider lane
	typedef struct packed {
		logic load;
		logic iter;
		logic fix;
	} lane_ctrl_t;

	// microcode
	localparam int STEP_W = 3;
	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV,
		OP_FIX,
		OP_MUL,
		OP_ACC
	} op_t;

	typedef enum logic [1:0] {
		C_ALWAYS,
		C_IN_VALID,
		C_CNT_ZERO,
		C_OUT_FREE
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		logic  run_always;
		step_t next_t;
		step_t next_f;
	} uword_t;

	localparam step_t ST_WAIT = 3'd0;
	localparam step_t ST_DIV  = 3'd1;
	localparam step_t ST_FIX  = 3'd2;
	localparam step_t ST_MUL  = 3'd3;
	localparam step_t ST_ACC  = 3'd4;

	// control store
	function automatic uword_t ucode(input step_t s);
		uword_t w;
		case (s)
			ST_WAIT: w = '{op: OP_LOAD, cond: C_IN_VALID, run_always: 1'b0,
				next_t: ST_DIV, next_f: ST_WAIT};
			ST_DIV:  w = '{op: OP_DIV, cond: C_CNT_ZERO, run_always: 1'b1,
				next_t: ST_FIX, next_f: ST_DIV};
			ST_FIX:  w = '{op: OP_FIX, cond: C_ALWAYS, run_always: 1'b0,
				next_t: ST_MUL, next_f: ST_MUL};
			ST_MUL:  w = '{op: OP_MUL, cond: C_ALWAYS, run_always: 1'b0,
				next_t: ST_ACC, next_f: ST_ACC};
			ST_ACC:  w = '{op: OP_ACC, cond: C_OUT_FREE, run_always: 1'b0,
				next_t: ST_WAIT, next_f: ST_ACC};
			default: w = '{op: OP_NONE, cond: C_ALWAYS, run_always: 1'b0,
				next_t: ST_WAIT, next_f: ST_WAIT};
		endcase
		return w;
	endfunction

endpackage

// ===== sv/gra_sample_if.sv =====
interface gra_sample_if;
	import gra_pkg::*;

	logic    valid;
	logic    ready;
	sample_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/gra_result_if.sv =====
interface gra_result_if;
	import gra_pkg::*;

	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/gyro_rate_angle_integrator.sv =====
// Gyro rate scaling and roll/pitch integration.
// The sample channel carries one raw three-axis rate sample with a start and
// a stop timestamp in ms. The result channel returns the three rates in whole
// deg/s and the roll and pitch angles in 1/2000 degree after the update.
// The user writes offsets and sensitivity on the cfg port only while the
// block is idle; the block itself does not enforce this. A small microcode
// sequencer steps the datapath: one accept step, 20 steps of a restoring
// divider (one quotient bit a cycle, three axis lanes side by side), then
// sign/saturate/deadband, multiply, and accumulate-and-publish. The block
// takes no new item until the accumulate step has published the last one.
// The result sits in an output register; while the receiver stalls the block
// waits in its last step and accepts nothing more until that register frees.
// Reset clears the previous rates, the angles, the offsets and sets the
// sensitivity to 1310 tenths of LSB per deg/s.
module gyro_rate_angle_integrator (
	input  logic                                clk,
	input  logic                                arst_n,
	gra_sample_if.sink                          sample,
	gra_result_if.source                        result,
	input  logic                                cfg_we,
	input  logic [gra_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [gra_pkg::CFG_W-1:0]           cfg_data
);
	import gra_pkg::*;

	localparam logic signed [SUM_W-1:0] ANG_MAX =
		SUM_W'($signed({1'b0, {(ANGLE_W-1){1'b1}}}));
	localparam logic signed [SUM_W-1:0] ANG_MIN = -ANG_MAX - SUM_W'(1);

	// configuration
	logic signed [RATE_W-1:0] off_x_q, off_y_q, off_z_q;
	logic        [DIVR_W-1:0] scale_q;

	// sequencer
	step_t            step_q;
	uword_t           uw;
	logic             cond_ok;
	logic             exec;
	logic [CNT_W-1:0] cnt_q;
	lane_ctrl_t       lctrl;

	// datapath
	logic        [DIVR_W-1:0]  divr_q;
	logic signed [TIME_W-1:0]  dt_q;
	logic signed [RATE_W-1:0]  rate_x, rate_y, rate_z;
	logic signed [RATE_W-1:0]  prev_x_q, prev_y_q, prev_z_q;
	logic signed [RSUM_W-1:0]  rsum_x, rsum_y;
	logic signed [INC_W-1:0]   prod_x, prod_y;
	logic signed [INC_W-1:0]   inc_x_q, inc_y_q;
	logic signed [ANGLE_W-1:0] roll_q, pitch_q;
	logic signed [ANGLE_W-1:0] roll_nx, pitch_nx;
	logic                      out_valid_q;
	result_t                   out_q;

	function automatic logic signed [ANGLE_W-1:0] sat_add(
		input logic signed [ANGLE_W-1:0] acc,
		input logic signed [INC_W-1:0]   inc
	);
		logic signed [SUM_W-1:0] s;
		s = SUM_W'(acc) + SUM_W'(inc);
		if (s > ANG_MAX) begin
			return ANG_MAX[ANGLE_W-1:0];
		end else if (s < ANG_MIN) begin
			return ANG_MIN[ANGLE_W-1:0];
		end
		return s[ANGLE_W-1:0];
	endfunction

	// control word and branch condition
	always_comb begin
		uw = ucode(step_q);
		case (uw.cond)
			C_ALWAYS:   cond_ok = 1'b1;
			C_IN_VALID: cond_ok = sample.valid;
			C_CNT_ZERO: cond_ok = (cnt_q == '0);
			C_OUT_FREE: cond_ok = !out_valid_q || result.ready;
			default:    cond_ok = 1'b1;
		endcase
		exec = cond_ok || uw.run_always;
	end

	assign sample.ready = (uw.cond == C_IN_VALID);

	assign lctrl.load = exec && (uw.op == OP_LOAD);
	assign lctrl.iter = exec && (uw.op == OP_DIV);
	assign lctrl.fix  = exec && (uw.op == OP_FIX);

	// step counter and iteration count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_WAIT;
			cnt_q  <= '0;
		end else begin
			step_q <= cond_ok ? uw.next_t : uw.next_f;
			if (lctrl.load) begin
				cnt_q <= CNT_W'(DIV_ITER - 1);
			end else if (lctrl.iter && cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= '0;
			off_y_q <= '0;
			off_z_q <= '0;
			scale_q <= RATE_SCALE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OFFSET_X:   off_x_q <= cfg_data;
				REG_OFFSET_Y:   off_y_q <= cfg_data;
				REG_OFFSET_Z:   off_z_q <= cfg_data;
				REG_RATE_SCALE: scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// interval and divisor captured with the item
	always_ff @(posedge clk) begin
		if (lctrl.load) begin
			dt_q   <= sample.data.time_stop_ms - sample.data.time_start_ms;
			divr_q <= (scale_q == '0) ? DIVR_W'(1) : scale_q;
		end
	end

	// one divider lane per axis
	gra_div_lane u_lane_x (
		.clk     (clk),
		.ctrl    (lctrl),
		.raw     (sample.data.raw_rate_x),
		.offset  (off_x_q),
		.divisor (divr_q),
		.prev    (prev_x_q),
		.rate    (rate_x)
	);

	gra_div_lane u_lane_y (
		.clk     (clk),
		.ctrl    (lctrl),
		.raw     (sample.data.raw_rate_y),
		.offset  (off_y_q),
		.divisor (divr_q),
		.prev    (prev_y_q),
		.rate    (rate_y)
	);

	gra_div_lane u_lane_z (
		.clk     (clk),
		.ctrl    (lctrl),
		.raw     (sample.data.raw_rate_z),
		.offset  (off_z_q),
		.divisor (divr_q),
		.prev    (prev_z_q),
		.rate    (rate_z)
	);

	// trapezoid increments
	always_comb begin
		rsum_x = RSUM_W'(rate_x) + RSUM_W'(prev_x_q);
		rsum_y = RSUM_W'(rate_y) + RSUM_W'(prev_y_q);
		prod_x = dt_q * rsum_x;
		prod_y = dt_q * rsum_y;
	end

	always_ff @(posedge clk) begin
		if (exec && uw.op == OP_MUL) begin
			inc_x_q <= prod_x;
			inc_y_q <= prod_y;
		end
	end

	// saturating accumulation
	always_comb begin
		roll_nx  = sat_add(roll_q, inc_x_q);
		pitch_nx = sat_add(pitch_q, inc_y_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_q   <= '0;
			pitch_q  <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_z_q <= '0;
		end else if (exec && uw.op == OP_ACC) begin
			roll_q   <= roll_nx;
			pitch_q  <= pitch_nx;
			prev_x_q <= rate_x;
			prev_y_q <= rate_y;
			prev_z_q <= rate_z;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec && uw.op == OP_ACC) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec && uw.op == OP_ACC) begin
			out_q.rate_x_dps  <= rate_x;
			out_q.rate_y_dps  <= rate_y;
			out_q.rate_z_dps  <= rate_z;
			out_q.roll_angle  <= roll_nx;
			out_q.pitch_angle <= pitch_nx;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

endmodule

// ===== sv/gra_div_lane.sv =====
module gra_div_lane (
	input  logic                               clk,
	input  gra_pkg::lane_ctrl_t                ctrl,
	input  logic signed [gra_pkg::RATE_W-1:0]  raw,
	input  logic signed [gra_pkg::RATE_W-1:0]  offset,
	input  logic        [gra_pkg::DIVR_W-1:0]  divisor,
	input  logic signed [gra_pkg::RATE_W-1:0]  prev,
	output logic signed [gra_pkg::RATE_W-1:0]  rate
);
	import gra_pkg::*;

	localparam logic [MAG_W-1:0] POS_LIM = MAG_W'(32767);
	localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(32768);

	logic signed [DIFF_W-1:0]  diff;
	logic signed [TIMES_W-1:0] times;
	logic        [MAG_W-1:0]   mag;
	logic        [MAG_W-1:0]   quo_q;
	logic        [REM_W-1:0]   rem_q;
	logic                      neg_q;
	logic        [REM_W-1:0]   trial;
	logic        [REM_W:0]     trial_sub;
	logic signed [RATE_W-1:0]  sat_val;
	logic signed [RATE_W-1:0]  rate_q;

	// offset removal, times ten, magnitude
	always_comb begin
		diff  = DIFF_W'(raw) - DIFF_W'(offset);
		times = (TIMES_W'(diff) <<< 3) + (TIMES_W'(diff) <<< 1);
		mag   = times[TIMES_W-1] ? MAG_W'(-times) : times[MAG_W-1:0];
	end

	// one restoring division step
	always_comb begin
		trial     = {rem_q[REM_W-2:0], quo_q[MAG_W-1]};
		trial_sub = {1'b0, trial} - {2'b00, divisor};
	end

	// sign, saturation to 16 bits, deadband against the previous rate
	always_comb begin
		if (!neg_q && quo_q > POS_LIM) begin
			sat_val = RATE_W'(32767);
		end else if (neg_q && quo_q > NEG_LIM) begin
			sat_val = -RATE_W'(32767) - RATE_W'(1);
		end else if (neg_q) begin
			sat_val = -RATE_W'(quo_q);
		end else begin
			sat_val = RATE_W'(quo_q);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			quo_q <= mag;
			rem_q <= '0;
			neg_q <= times[TIMES_W-1];
		end else if (ctrl.iter) begin
			if (!trial_sub[REM_W]) begin
				rem_q <= trial_sub[REM_W-1:0];
				quo_q <= {quo_q[MAG_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[MAG_W-2:0], 1'b0};
			end
		end
		if (ctrl.fix) begin
			if ((sat_val == RATE_W'(1) || sat_val == -RATE_W'(1)) && prev == '0) begin
				rate_q <= '0;
			end else begin
				rate_q <= sat_val;
			end
		end
	end

	assign rate = rate_q;

endmodule
